FILE: hdl/wse_pkg.sv
package wse_pkg;

   localparam int FILTER_LEN = 10;
   localparam int PTR_W      = (FILTER_LEN > 1) ? $clog2(FILTER_LEN) : 1;
   localparam int SPEED_W    = 16;
   localparam int SUM_W      = SPEED_W + ((FILTER_LEN > 1) ? $clog2(FILTER_LEN) : 1);
   localparam int TIME_W     = 32;
   localparam int TICK_W     = 20;
   localparam int PROD_W     = 30;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // sum / FILTER_LEN == (sum * AVG_RECIP) >> AVG_SHIFT for every sum below 2^SUM_W
   localparam int AVG_SHIFT  = SUM_W + PTR_W;
   localparam int AVG_PROD_W = SUM_W + AVG_SHIFT + 1;
   localparam logic [AVG_SHIFT:0] AVG_RECIP =
      (AVG_SHIFT+1)'(((64'd1 << AVG_SHIFT) + 64'(FILTER_LEN) - 64'd1) / 64'(FILTER_LEN));

   localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
   localparam logic [9:0]         UM_PER_MM = 10'd1000;

   localparam logic [TICK_W-1:0]  TICK_DISTANCE_RESET = 20'd24300;
   localparam logic [SPEED_W-1:0] SPIKE_MARGIN_RESET  = 16'd1000;
   localparam logic [TIME_W-1:0]  TIMEOUT_RESET       = 32'd50000;

   localparam logic [CSR_IDX_W-1:0] CSR_TICK_DISTANCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIKE_MARGIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT       = 2'd2;

   localparam logic OP_EDGE  = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   typedef struct packed {
      logic              op;
      logic [TIME_W-1:0] time_us;
   } req_type;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_mm_s;
      logic               speed_updated;
   } rsp_type;

endpackage

FILE: hdl/wheel_speed_estimator_core.sv
// Wheel speed estimator. Each item is an encoder edge or a timeout check with a
// microsecond timestamp, and each gives exactly one result: the stored speed in
// mm/s and a flag that says whether the item changed it. An edge that follows an
// earlier edge first passes a saturation check, then one restoring divider, one
// quotient bit per cycle, runs 16 steps for the sample (tick distance * 1000 /
// interval), then the ring update, the average (sum / FILTER_LEN by a constant
// reciprocal multiply), the spike compare and the output load follow in turn. A
// sample that saturates at 65535 is detected before the divide and skips it. A
// first edge or a check goes straight to the output load. The input is not ready
// while an item is in work and is ready again once the output register is loaded;
// a finished result sits in an output register, so the next item can be taken
// while it waits, and that item holds in its last cycle until the register frees
// up. Configuration writes take effect at once; the user must make them only in
// idle periods, as the block itself does not enforce this.
module wheel_speed_estimator_core import wse_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAT_CHECK,
      ST_DIV_SPEED,
      ST_RING,
      ST_AVG,
      ST_AVG_CMP,
      ST_FINISH
   } state_type;

   state_type state_ff;

   logic [TICK_W-1:0]  tick_ff;
   logic [SPEED_W-1:0] margin_ff;
   logic [TIME_W-1:0]  timeout_ff;

   logic [SPEED_W-1:0] ring_ff [FILTER_LEN];
   logic [PTR_W-1:0]   ptr_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [TIME_W-1:0]  prev_ff;
   logic               have_prev_ff;
   logic [SPEED_W-1:0] speed_ff;

   logic [PROD_W-1:0]  product_ff;
   logic [TIME_W-1:0]  divisor_ff;
   logic [TIME_W-1:0]  rem_ff;
   logic [SPEED_W-1:0] quo_ff;
   logic [3:0]         step_ff;
   logic [SPEED_W-1:0] sample_ff;
   logic [SPEED_W-1:0] new_speed_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // divider step
   logic [TIME_W:0]    trial_in;
   logic               ge_in;
   logic [TIME_W-1:0]  rem_in;
   logic [SPEED_W-1:0] quo_in;

   logic               accept_in;
   logic [TIME_W-1:0]  elapsed_in;
   logic [PROD_W-1:0]  product_in;
   logic [SUM_W-1:0]   sum_in;
   logic [AVG_PROD_W-1:0] avg_prod_in;
   logic [SPEED_W:0]   limit_in;
   logic               out_free_in;

   always_comb begin
      trial_in  = {rem_ff, quo_ff[SPEED_W-1]};
      ge_in     = trial_in >= {1'b0, divisor_ff};
      rem_in    = ge_in ? TIME_W'(trial_in - {1'b0, divisor_ff}) : trial_in[TIME_W-1:0];
      quo_in    = {quo_ff[SPEED_W-2:0], ge_in};
   end

   assign accept_in   = req_valid && req_ready;
   assign elapsed_in  = req_payload.time_us - prev_ff;
   assign product_in  = PROD_W'(tick_ff) * PROD_W'(UM_PER_MM);
   assign sum_in      = sum_ff - SUM_W'(ring_ff[ptr_ff]) + SUM_W'(sample_ff);
   assign avg_prod_in = AVG_PROD_W'(sum_ff) * AVG_PROD_W'(AVG_RECIP);
   assign limit_in    = {1'b0, speed_ff} + {1'b0, margin_ff};
   assign out_free_in = !rsp_valid_ff || rsp_ready;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= TICK_DISTANCE_RESET;
         margin_ff    <= SPIKE_MARGIN_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         for (int i = 0; i < FILTER_LEN; i++) begin
            ring_ff[i] <= '0;
         end
         ptr_ff       <= '0;
         sum_ff       <= '0;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_TICK_DISTANCE: tick_ff    <= csr_wdata[TICK_W-1:0];
               CSR_SPIKE_MARGIN:  margin_ff  <= csr_wdata[SPEED_W-1:0];
               CSR_TIMEOUT:       timeout_ff <= csr_wdata[TIME_W-1:0];
               default: ;
            endcase
         end

         // a finishing item reloads the output register in the same cycle
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept_in) begin
                  if (req_payload.op == OP_EDGE) begin
                     prev_ff      <= req_payload.time_us;
                     have_prev_ff <= 1'b1;
                     new_speed_ff <= speed_ff;
                     divisor_ff   <= elapsed_in;
                     product_ff   <= product_in;
                     state_ff     <= have_prev_ff ? ST_SAT_CHECK : ST_FINISH;
                  end else begin
                     new_speed_ff <= (!have_prev_ff || elapsed_in > timeout_ff) ?
                                     '0 : speed_ff;
                     state_ff     <= ST_FINISH;
                  end
               end
            end
            ST_SAT_CHECK: begin
               // quotient fits 16 bits only if the high part is below the divisor;
               // a zero interval always saturates here
               if (TIME_W'(product_ff >> SPEED_W) >= divisor_ff) begin
                  sample_ff <= SPEED_MAX;
                  state_ff  <= ST_RING;
               end else begin
                  rem_ff   <= TIME_W'(product_ff >> SPEED_W);
                  quo_ff   <= product_ff[SPEED_W-1:0];
                  step_ff  <= '0;
                  state_ff <= ST_DIV_SPEED;
               end
            end
            ST_DIV_SPEED: begin
               rem_ff  <= rem_in;
               quo_ff  <= quo_in;
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'(SPEED_W - 1)) begin
                  sample_ff <= quo_in;
                  state_ff  <= ST_RING;
               end
            end
            ST_RING: begin
               ring_ff[ptr_ff] <= sample_ff;
               sum_ff          <= sum_in;
               ptr_ff          <= (ptr_ff == PTR_W'(FILTER_LEN - 1)) ? '0 : ptr_ff + PTR_W'(1);
               state_ff        <= ST_AVG;
            end
            ST_AVG: begin
               // the average of 16-bit samples always fits 16 bits
               quo_ff   <= avg_prod_in[AVG_SHIFT +: SPEED_W];
               state_ff <= ST_AVG_CMP;
            end
            ST_AVG_CMP: begin
               // spike rejection: take the average only below speed + margin
               new_speed_ff <= ({1'b0, quo_ff} < limit_in) ? quo_ff : speed_ff;
               state_ff     <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free_in) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_ff.speed_mm_s    <= new_speed_ff;
                  rsp_ff.speed_updated <= (new_speed_ff != speed_ff);
                  speed_ff             <= new_speed_ff;
                  state_ff             <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: hdl/wse_checker.sv
module wse_checker import wse_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_type               rsp_payload
);

   // speed carried by the last delivered item
   logic [SPEED_W-1:0] last_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_speed_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         last_speed_ff <= rsp_payload.speed_mm_s;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result item dropped or changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready did not drop after an item was taken");

   a_updated_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |->
         rsp_payload.speed_updated == (rsp_payload.speed_mm_s != last_speed_ff))
      else $error("speed_updated disagrees with the change of speed");

endmodule

bind wheel_speed_estimator_core wse_checker u_wse_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
